/* hdl/mbsw_pkg.sv */
package mbsw_pkg;

   localparam int MAX_NEST_DEFAULT    = 15;
   localparam int OFFSET_BITS_DEFAULT = 48;

   localparam logic [31:0] TYPE_UUID = 32'h75756964;
   localparam logic [31:0] TYPE_DREF = 32'h64726566;
   localparam logic [31:0] TYPE_STSD = 32'h73747364;
   localparam logic [31:0] TYPE_META = 32'h6D657461;
   localparam logic [31:0] TYPE_MP4A = 32'h6D703461;

   localparam int NUM_CONTAINERS = 24;
   localparam logic [31:0] CONTAINER_TYPES [NUM_CONTAINERS] = '{
      32'h61415254, 32'h61704944, 32'h636E4944, 32'h636F7672, 32'h64696E66, 32'h6469736B,
      32'h696C7374, 32'h6D646961, 32'h6D696E66, 32'h6D6F6F76, 32'h6F776E72, 32'h70757264,
      32'h736F6161, 32'h736F6172, 32'h7374626C, 32'h7374696B, 32'h7472616B, 32'h74726B6E,
      32'h75647461, 32'hA9415254, 32'hA9616C62, 32'hA9646179, 32'hA96E616D, 32'h2D2D2D2D
   };

   typedef enum logic [2:0] {
      EV_BOX      = 3'd0,
      EV_HEADER   = 3'd1,
      EV_OVERRUN  = 3'd2,
      EV_FIXED    = 3'd3,
      EV_DEEP     = 3'd4,
      EV_EOF      = 3'd5
   } event_kind_type;

   typedef enum logic [1:0] {
      PH_HEAD  = 2'd0,
      PH_SKIP  = 2'd1,
      PH_FIXED = 2'd2,
      PH_STOP  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_SETTLE,
      ST_FINAL,
      ST_EMIT
   } seq_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [47:0] box_offset;
      logic [3:0]  nest_level;
      logic [47:0] box_length;
      logic [31:0] box_kind;
      logic [63:0] uuid_upper;
      logic [63:0] uuid_lower;
      logic        run_last;
   } result_type;

   function automatic logic is_container(input logic [31:0] t);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < NUM_CONTAINERS; i++)
         if (CONTAINER_TYPES[i] == t) hit = 1'b1;
      return hit;
   endfunction

endpackage

/* hdl/mbsw_if.sv */
interface mbsw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_final;
   modport source (output valid, output data_byte, output is_final, input ready);
   modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

interface mbsw_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [47:0] box_offset;
   logic [3:0]  nest_level;
   logic [47:0] box_length;
   logic [31:0] box_kind;
   logic [63:0] uuid_upper;
   logic [63:0] uuid_lower;
   logic        run_last;
   modport source (output valid, output event_kind, output box_offset, output nest_level,
                   output box_length, output box_kind, output uuid_upper,
                   output uuid_lower, output run_last, input ready);
   modport sink   (input valid, input event_kind, input box_offset, input nest_level,
                   input box_length, input box_kind, input uuid_upper,
                   input uuid_lower, input run_last, output ready);
endinterface

/* hdl/mbsw_result_queue.sv */
module mbsw_result_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mbsw_pkg::result_type push_data,
   input  logic                mark,
   input  logic                show,
   output logic                empty,
   mbsw_rsp_if.source          rsp
);
   import mbsw_pkg::*;

   result_type mem_ff [4];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;

   assign pop   = rsp.valid && rsp.ready;
   assign empty = (cnt_ff == 3'd0);

   always_comb begin
      wr_in  = push ? wr_ff + 2'd1 : wr_ff;
      rd_in  = pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'b0, push} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
      else if (mark) mem_ff[wr_ff - 2'd1].run_last <= 1'b1;
   end

   assign rsp.valid      = !empty && show;
   assign rsp.event_kind = mem_ff[rd_ff].event_kind;
   assign rsp.box_offset = mem_ff[rd_ff].box_offset;
   assign rsp.nest_level = mem_ff[rd_ff].nest_level;
   assign rsp.box_length = mem_ff[rd_ff].box_length;
   assign rsp.box_kind   = mem_ff[rd_ff].box_kind;
   assign rsp.uuid_upper = mem_ff[rd_ff].uuid_upper;
   assign rsp.uuid_lower = mem_ff[rd_ff].uuid_lower;
   assign rsp.run_last   = mem_ff[rd_ff].run_last;

endmodule

/* hdl/mp4_box_structure_walker_top.sv */
// An item's results are held in the result queue and offered together once its processing is done.
// A byte passes through ST_HEAD while a box header is being read, then ST_SETTLE, which
// repeats for each box started, container entered or level popped from the end-of-container
// stack; the last byte of a file also passes ST_FINAL and ST_EMIT for the final check. The
// next byte waits until every result of the previous one has been taken.
// Reset: synchronous, active high; clears position, depth, phase and the result queue.
module mp4_box_structure_walker_top #(
   parameter int MAX_NEST    = mbsw_pkg::MAX_NEST_DEFAULT,
   parameter int OFFSET_BITS = mbsw_pkg::OFFSET_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   mbsw_req_if.sink   req,
   mbsw_rsp_if.source rsp
);
   import mbsw_pkg::*;

   localparam int DW = $clog2(MAX_NEST + 1);
   localparam int SW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
   localparam logic [OFFSET_BITS-1:0] OMASK = '1;

   seq_type   st_ff, st_in;
   phase_type ph_ff, ph_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in, start_ff, start_in, end_ff, end_in;
   logic [OFFSET_BITS-1:0] frel_ff, frel_in;
   logic [63:0] hs_ff, hs_in, u0_ff, u0_in, u1_ff, u1_in;
   logic [31:0] sw_ff, sw_in, bt_ff, bt_in;
   logic        sk_ff, sk_in, ek_ff, ek_in, last_ff, last_in;
   logic [7:0]  byte_ff;
   logic [DW-1:0] dep_ff, dep_in, open_ff, open_in;
   logic [OFFSET_BITS-1:0] len_ff, len_in;
   logic [1:0]  nres_ff, nres_in;

   logic [OFFSET_BITS-1:0] end_stack [MAX_NEST];
   logic [OFFSET_BITS-1:0] start_stack [MAX_NEST];
   logic        push_stack;
   logic [SW-1:0] push_idx;
   logic [OFFSET_BITS-1:0] top_end, open_end, open_start;

   result_type ev;
   logic       ev_push, ev_mark, q_show, q_empty;

   assign push_idx   = SW'(dep_ff);
   assign top_end    = (dep_ff != '0) ? end_stack[SW'(dep_ff - DW'(1))] : '0;
   assign open_end   = (open_ff < DW'(MAX_NEST)) ? end_stack[SW'(open_ff)] : '0;
   assign open_start = (open_ff < DW'(MAX_NEST)) ? start_stack[SW'(open_ff)] : '0;

   always_ff @(posedge clock) begin
      if (push_stack) begin
         end_stack[push_idx]   <= end_ff;
         start_stack[push_idx] <= start_ff;
      end
   end

   assign ev_mark = (st_ff != ST_IDLE) && (st_in == ST_IDLE) && !ev_push;
   assign q_show  = (st_ff == ST_IDLE);

   mbsw_result_queue u_queue (
      .clock(clock), .reset(reset), .push(ev_push), .push_data(ev),
      .mark(ev_mark), .show(q_show), .empty(q_empty), .rsp(rsp)
   );

   assign req.ready = (st_ff == ST_IDLE) && q_empty;

   function automatic result_type mk(input event_kind_type k,
                                     input logic [OFFSET_BITS-1:0] off,
                                     input logic [DW-1:0] lvl);
      result_type r;
      r = '0;
      r.event_kind = k;
      r.box_offset = 48'(off);
      r.nest_level = 4'(lvl);
      return r;
   endfunction

   logic cont_known;
   assign cont_known = dep_ff > open_ff;

   always_comb begin
      logic [OFFSET_BITS-1:0] g, gath, rel, lim, hl, tot, fx, sz;
      logic [63:0] szw;
      logic [3:0]  u;
      logic        lmt, sk, ek, done, zero, ovf;
      logic [31:0] swn, btn;
      st_in = st_ff; ph_in = ph_ff; pos_in = pos_ff; start_in = start_ff;
      end_in = end_ff; frel_in = frel_ff; hs_in = hs_ff; u0_in = u0_ff; u1_in = u1_ff;
      sw_in = sw_ff; bt_in = bt_ff; sk_in = sk_ff; ek_in = ek_ff; last_in = last_ff;
      dep_in = dep_ff; open_in = open_ff; len_in = len_ff; nres_in = nres_ff;
      push_stack = 1'b0; ev = '0; ev_push = 1'b0;
      g = '0; gath = '0; rel = '0; lim = '0; hl = '0; tot = '0; fx = '0; sz = '0;
      szw = '0; u = '0; lmt = 1'b0; sk = 1'b0; ek = 1'b0; done = 1'b0; zero = 1'b0;
      ovf = 1'b0; swn = '0; btn = '0;
      case (st_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               last_in = req.is_final;
               nres_in = '0;
               if (ph_ff == PH_HEAD) st_in = ST_HEAD;
               else begin
                  pos_in = pos_ff + OFFSET_BITS'(1);
                  st_in  = ST_SETTLE;
               end
            end
         end
         ST_HEAD: begin
            g = pos_ff - start_ff;
            pos_in = pos_ff + OFFSET_BITS'(1);
            swn = sw_ff; btn = bt_ff;
            if (g < OFFSET_BITS'(4)) swn = {sw_ff[23:0], byte_ff};
            else if (g < OFFSET_BITS'(8)) btn = {bt_ff[23:0], byte_ff};
            else if (sw_ff == 32'd1 && g < OFFSET_BITS'(16)) hs_in = {hs_ff[55:0], byte_ff};
            else begin
               u = 4'(g - ((sw_ff == 32'd1) ? OFFSET_BITS'(16) : OFFSET_BITS'(8)));
               if ((g - ((sw_ff == 32'd1) ? OFFSET_BITS'(16) : OFFSET_BITS'(8)))
                   < OFFSET_BITS'(16)) begin
                  if (!u[3]) u0_in = {u0_ff[55:0], byte_ff};
                  else u1_in = {u1_ff[55:0], byte_ff};
               end
            end
            sw_in = swn; bt_in = btn;
            gath = g + OFFSET_BITS'(1);
            sk = sk_ff; ek = ek_ff;
            done = 1'b0;
            if (!sk_ff && ((gath == OFFSET_BITS'(8) && swn != 32'd1) ||
                           (gath == OFFSET_BITS'(16) && swn == 32'd1))) begin
               zero = (gath == OFFSET_BITS'(8)) && (swn == 32'd0);
               szw  = (gath == OFFSET_BITS'(8)) ? {32'd0, swn} : hs_in;
               if (zero) begin
                  ek = cont_known;
                  if (ek) end_in = top_end;
                  len_in = ek ? top_end - start_ff : '0;
                  sk = 1'b1;
               end else begin
                  lim = cont_known ? top_end - start_ff : OMASK - start_ff;
                  ovf = (szw > {{(64-OFFSET_BITS){1'b0}}, lim});
                  if (ovf) begin
                     ev = mk(EV_OVERRUN, start_ff, dep_ff); ev_push = 1'b1;
                     nres_in = nres_ff + 2'd1;
                     done = 1'b1;
                     if (dep_ff == '0) ph_in = PH_STOP;
                     else begin
                        ph_in = PH_SKIP; end_in = top_end; ek = cont_known;
                     end
                  end else begin
                     sz = OFFSET_BITS'(szw);
                     end_in = start_ff + sz; ek = 1'b1; len_in = sz; sk = 1'b1;
                  end
               end
            end
            sk_in = sk; ek_in = ek;
            if (!done) begin
               hl  = (swn == 32'd1) ? OFFSET_BITS'(16) : OFFSET_BITS'(8);
               tot = hl + ((btn == TYPE_UUID) ? OFFSET_BITS'(16) : OFFSET_BITS'(0));
               if (sk && gath == tot) begin
                  ev = '0;
                  ev.event_kind = EV_BOX;
                  ev.box_offset = 48'(start_ff);
                  ev.nest_level = 4'(dep_ff);
                  ev.box_length = 48'(len_in);
                  ev.box_kind   = btn;
                  ev.uuid_upper = (btn == TYPE_UUID) ? u0_in : '0;
                  ev.uuid_lower = (btn == TYPE_UUID) ? u1_in : '0;
                  ev_push = 1'b1; nres_in = nres_ff + 2'd1;
                  if (is_container(btn)) begin
                     frel_in = gath; ph_in = PH_FIXED;
                  end else begin
                     fx = (btn == TYPE_DREF || btn == TYPE_STSD) ? OFFSET_BITS'(8) :
                          (btn == TYPE_META) ? OFFSET_BITS'(4) :
                          (btn == TYPE_MP4A) ? OFFSET_BITS'(28) : '0;
                     if (fx != '0) begin ph_in = PH_FIXED; frel_in = gath + fx; end
                     else ph_in = PH_SKIP;
                  end
               end else begin
                  if (sk && ek) begin rel = end_in - start_ff; lmt = 1'b1; end
                  else if (cont_known) begin rel = top_end - start_ff; lmt = 1'b1; end
                  if (lmt && gath >= rel) begin
                     ev = mk(EV_HEADER, start_ff, dep_ff); ev_push = 1'b1;
                     nres_in = nres_ff + 2'd1;
                     if (dep_ff == '0) ph_in = PH_STOP;
                     else begin
                        ph_in = PH_SKIP; end_in = top_end; ek_in = cont_known;
                     end
                  end
               end
            end
            st_in = ST_SETTLE;
         end
         ST_SETTLE: begin
            st_in = last_ff ? ST_FINAL : ST_IDLE;
            if (dep_ff != '0 && cont_known && top_end == pos_ff &&
                (ph_ff == PH_HEAD) && (pos_ff == start_ff)) begin
               dep_in = dep_ff - DW'(1);
               st_in  = ST_SETTLE;
            end else if (ph_ff == PH_SKIP && ek_ff && pos_ff == end_ff) begin
               ph_in = PH_HEAD; start_in = pos_ff; hs_in = '0; u0_in = '0; u1_in = '0;
               sw_in = '0; bt_in = '0; sk_in = 1'b0; ek_in = 1'b0; len_in = '0;
               st_in = ST_SETTLE;
            end else if (ph_ff == PH_FIXED && (pos_ff - start_ff) == frel_ff) begin
               if (dep_ff >= DW'(MAX_NEST)) begin
                  if (nres_ff < 2'd3) begin
                     ev = mk(EV_DEEP, start_ff, dep_ff); ev_push = 1'b1;
                     nres_in = nres_ff + 2'd1;
                  end
                  ph_in = PH_STOP;
               end else begin
                  push_stack = 1'b1;
                  if (!ek_ff) open_in = dep_ff + DW'(1);
                  dep_in = dep_ff + DW'(1);
                  ph_in = PH_HEAD; start_in = pos_ff; hs_in = '0; u0_in = '0; u1_in = '0;
                  sw_in = '0; bt_in = '0; sk_in = 1'b0; ek_in = 1'b0; len_in = '0;
                  st_in = ST_SETTLE;
               end
            end else if (ph_ff == PH_FIXED && ek_ff && pos_ff == end_ff) begin
               if (nres_ff < 2'd3) begin
                  ev = mk(EV_FIXED, start_ff, dep_ff); ev_push = 1'b1;
                  nres_in = nres_ff + 2'd1;
               end
               ph_in = PH_HEAD; start_in = pos_ff; hs_in = '0; u0_in = '0; u1_in = '0;
               sw_in = '0; bt_in = '0; sk_in = 1'b0; ek_in = 1'b0; len_in = '0;
               st_in = ST_SETTLE;
            end
         end
         ST_FINAL: begin
            st_in = ST_EMIT;
            if (nres_ff < 2'd2 && ph_ff != PH_STOP) begin
               if (open_ff < dep_ff) begin
                  if (open_end != pos_ff) begin
                     ev = mk(EV_OVERRUN, open_start, open_ff); ev_push = 1'b1;
                  end
               end else if (ph_ff == PH_HEAD) begin
                  if (pos_ff != start_ff) begin
                     ev = mk((sk_ff && ek_ff) ? EV_OVERRUN : EV_HEADER, start_ff, dep_ff);
                     ev_push = 1'b1;
                  end
               end else if (ph_ff == PH_SKIP) begin
                  if (ek_ff && end_ff != pos_ff) begin
                     ev = mk(EV_OVERRUN, start_ff, dep_ff); ev_push = 1'b1;
                  end
               end else begin
                  ev = mk(ek_ff ? EV_OVERRUN : EV_FIXED, start_ff, dep_ff); ev_push = 1'b1;
               end
            end
            if (ev_push) nres_in = nres_ff + 2'd1;
         end
         ST_EMIT: begin
            if (nres_ff < 2'd3) begin
               ev = mk(EV_EOF, pos_ff, '0); ev_push = 1'b1;
            end
            ph_in = PH_HEAD; pos_in = '0; start_in = '0; end_in = '0; frel_in = '0;
            hs_in = '0; u0_in = '0; u1_in = '0; sw_in = '0; bt_in = '0;
            sk_in = 1'b0; ek_in = 1'b0; dep_in = '0; open_in = '0; len_in = '0;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
      if (ev_push && (st_in == ST_IDLE || st_ff == ST_EMIT)) ev.run_last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) byte_ff <= req.data_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; ph_ff <= PH_HEAD; pos_ff <= '0; start_ff <= '0; end_ff <= '0;
         frel_ff <= '0; hs_ff <= '0; u0_ff <= '0; u1_ff <= '0; sw_ff <= '0; bt_ff <= '0;
         sk_ff <= 1'b0; ek_ff <= 1'b0; last_ff <= 1'b0; dep_ff <= '0; open_ff <= '0;
         len_ff <= '0; nres_ff <= '0;
      end else begin
         st_ff <= st_in; ph_ff <= ph_in; pos_ff <= pos_in; start_ff <= start_in;
         end_ff <= end_in; frel_ff <= frel_in; hs_ff <= hs_in; u0_ff <= u0_in;
         u1_ff <= u1_in; sw_ff <= sw_in; bt_ff <= bt_in; sk_ff <= sk_in; ek_ff <= ek_in;
         last_ff <= last_in; dep_ff <= dep_in; open_ff <= open_in; len_ff <= len_in;
         nres_ff <= nres_in;
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> st_ff == ST_IDLE) else $error("ready outside idle");
   a_open_le_dep: assert property (@(posedge clock) disable iff (reset)
      open_ff <= dep_ff) else $error("open levels exceed depth");
   a_eof_reset: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_EMIT |=> dep_ff == '0 && pos_ff == '0) else $error("file end not cleared");

endmodule

/* bench/mp4_box_structure_walker_top_tb.sv */
`timescale 1ns / 1ps

module mp4_box_structure_walker_top_tb;
   import mbsw_pkg::*;

   localparam int          LEVELS    = 15;
   localparam logic [63:0] POS_MASK  = 64'h0000_FFFF_FFFF_FFFF;
   localparam int          STALL_MAX = 3000;
   localparam int          HOLD_LEN  = 400;

   logic clock;
   logic reset;

   mbsw_req_if req ();
   mbsw_rsp_if rsp ();

   mp4_box_structure_walker_top DUT (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   class walk_scoreboard;
      result_type  due_q[$];
      result_type  step_q[$];
      int          errors;
      logic [63:0] pos, hshift, cstart, cend, blen, fixed_rel;
      logic [63:0] ush [2];
      logic [63:0] ends [LEVELS];
      logic [63:0] starts [LEVELS];
      phase_type   phase;
      int          depth, open_lv;
      logic [31:0] size_word, btype;
      bit          size_known, end_known;

      function new();
         errors = 0;
         clear_walk();
      endfunction

      function void emit(event_kind_type k, logic [63:0] off, int lvl, logic [63:0] len,
                         logic [31:0] t, logic [63:0] u0, logic [63:0] u1);
         result_type r;
         if (step_q.size() >= 3) return;
         r.event_kind = k;
         r.box_offset = off[47:0];
         r.nest_level = lvl[3:0];
         r.box_length = len[47:0];
         r.box_kind   = t;
         r.uuid_upper = u0;
         r.uuid_lower = u1;
         r.run_last   = 1'b0;
         step_q.push_back(r);
      endfunction

      function bit outer_known();
         return depth > open_lv;
      endfunction

      function void next_box();
         while (depth > 0 && depth > open_lv && ends[depth-1] == pos) depth--;
         phase = PH_HEAD;
         cstart = pos;
         hshift = 0; ush[0] = 0; ush[1] = 0;
         size_word = 0; btype = 0; size_known = 0; end_known = 0; blen = 0;
      endfunction

      function void skip_container();
         if (depth == 0) begin
            phase = PH_STOP;
            return;
         end
         phase = PH_SKIP;
         cend = ends[depth-1];
         end_known = outer_known();
      endfunction

      function void descend();
         if (depth >= LEVELS) begin
            emit(EV_DEEP, cstart, depth, 0, 0, 0, 0);
            phase = PH_STOP;
            return;
         end
         ends[depth] = cend;
         starts[depth] = cstart;
         if (!end_known) open_lv = depth + 1;
         depth++;
         next_box();
      endfunction

      function void settle();
         forever begin
            if (phase == PH_SKIP && end_known && pos == cend) begin
               next_box();
               continue;
            end
            if (phase == PH_FIXED) begin
               if (((pos - cstart) & POS_MASK) == fixed_rel) begin
                  descend();
                  continue;
               end
               if (end_known && pos == cend) begin
                  emit(EV_FIXED, cstart, depth, 0, 0, 0, 0);
                  next_box();
                  continue;
               end
            end
            break;
         end
      endfunction

      function void take_size(logic [63:0] sz, bit zero);
         logic [63:0] lim;
         if (zero) begin
            end_known = outer_known();
            if (end_known) cend = ends[depth-1];
            blen = end_known ? ((cend - cstart) & POS_MASK) : 0;
         end else begin
            lim = outer_known() ? ((ends[depth-1] - cstart) & POS_MASK) : (POS_MASK - cstart);
            if (sz > lim) begin
               emit(EV_OVERRUN, cstart, depth, 0, 0, 0, 0);
               skip_container();
               return;
            end
            cend = (cstart + sz) & POS_MASK;
            end_known = 1;
            blen = sz;
         end
         size_known = 1;
      endfunction

      function void header_done(logic [63:0] gathered);
         logic [63:0] fixed;
         bit          uu;
         fixed = 0;
         uu = (btype == TYPE_UUID);
         emit(EV_BOX, cstart, depth, blen, btype, uu ? ush[0] : 64'd0, uu ? ush[1] : 64'd0);
         foreach (CONTAINER_TYPES[i])
            if (CONTAINER_TYPES[i] == btype) begin
               descend();
               return;
            end
         if (btype == TYPE_DREF || btype == TYPE_STSD) fixed = 8;
         else if (btype == TYPE_META) fixed = 4;
         else if (btype == TYPE_MP4A) fixed = 28;
         if (fixed != 0) begin
            phase = PH_FIXED;
            fixed_rel = gathered + fixed;
         end else phase = PH_SKIP;
      endfunction

      function void header_byte(logic [7:0] b);
         logic [63:0] g, gathered, hl, total, rel, u;
         bit          limited;
         rel = 0;
         limited = 0;
         g = (pos - cstart) & POS_MASK;
         pos = (pos + 1) & POS_MASK;
         if (g < 4) size_word = {size_word[23:0], b};
         else if (g < 8) btype = {btype[23:0], b};
         else if (size_word == 1 && g < 16) hshift = {hshift[55:0], b};
         else begin
            u = g - (size_word == 1 ? 64'd16 : 64'd8);
            if (u < 16) ush[u[3]] = {ush[u[3]][55:0], b};
         end
         gathered = g + 1;
         if (!size_known) begin
            if (gathered == 8 && size_word != 1) take_size({32'd0, size_word}, size_word == 0);
            else if (gathered == 16 && size_word == 1) take_size(hshift, 0);
         end
         if (phase != PH_HEAD) return;
         hl = (size_word == 1) ? 16 : 8;
         total = hl + ((btype == TYPE_UUID) ? 16 : 0);
         if (size_known && gathered == total) begin
            header_done(gathered);
            return;
         end
         if (size_known && end_known) begin
            rel = (cend - cstart) & POS_MASK;
            limited = 1;
         end else if (outer_known()) begin
            rel = (ends[depth-1] - cstart) & POS_MASK;
            limited = 1;
         end
         if (limited && gathered >= rel) begin
            emit(EV_HEADER, cstart, depth, 0, 0, 0, 0);
            skip_container();
         end
      endfunction

      function void file_end_status();
         int k;
         k = open_lv;
         if (phase == PH_STOP) return;
         if (k < depth) begin
            if (ends[k] != pos) emit(EV_OVERRUN, starts[k], k, 0, 0, 0, 0);
            return;
         end
         if (phase == PH_HEAD) begin
            if (((pos - cstart) & POS_MASK) == 0) return;
            emit((size_known && end_known) ? EV_OVERRUN : EV_HEADER, cstart, depth, 0, 0, 0, 0);
         end else if (phase == PH_SKIP) begin
            if (end_known && cend != pos) emit(EV_OVERRUN, cstart, depth, 0, 0, 0, 0);
         end else if (phase == PH_FIXED) begin
            emit(end_known ? EV_OVERRUN : EV_FIXED, cstart, depth, 0, 0, 0, 0);
         end
      endfunction

      function void clear_walk();
         pos = 0; depth = 0; open_lv = 0; cend = 0; fixed_rel = 0;
         foreach (ends[i]) begin
            ends[i] = 0;
            starts[i] = 0;
         end
         next_box();
      endfunction

      function void note_byte(logic [7:0] b, logic fin);
         step_q.delete();
         if (phase == PH_HEAD) header_byte(b);
         else pos = (pos + 1) & POS_MASK;
         settle();
         if (fin) begin
            if (step_q.size() < 2) file_end_status();
            emit(EV_EOF, pos, 0, 0, 0, 0, 0);
            clear_walk();
         end
         if (step_q.size() > 0) step_q[$].run_last = 1'b1;
         foreach (step_q[i]) due_q.push_back(step_q[i]);
      endfunction

      function void field(string name, logic [63:0] e, logic [63:0] a);
         if (e !== a) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
            errors++;
         end
      endfunction

      function void check(result_type got);
         result_type e;
         if (due_q.size() == 0) begin
            $display("%0t unexpected result: expected none actual %p", $time, got);
            errors++;
            return;
         end
         e = due_q.pop_front();
         field("event_kind", e.event_kind, got.event_kind);
         field("box_offset", e.box_offset, got.box_offset);
         field("nest_level", e.nest_level, got.nest_level);
         field("box_length", e.box_length, got.box_length);
         field("box_kind", e.box_kind, got.box_kind);
         field("uuid_upper", e.uuid_upper, got.uuid_upper);
         field("uuid_lower", e.uuid_lower, got.uuid_lower);
         field("run_last", e.run_last, got.run_last);
      endfunction
   endclass

   walk_scoreboard box_sb;
   int  send_idle, recv_idle;
   bit  hold_go;
   int  hold_left;
   int  quiet_cycles;
   int  bytes_sent;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         box_sb.check('{rsp.event_kind, rsp.box_offset, rsp.nest_level, rsp.box_length,
                        rsp.box_kind, rsp.uuid_upper, rsp.uuid_lower, rsp.run_last});
      if (hold_go) begin
         hold_go = 1'b0;
         hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else rsp.ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_MAX) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_byte(logic [7:0] b, logic fin);
      while ($urandom_range(0, 99) < send_idle) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.data_byte <= b;
      req.is_final  <= fin;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      box_sb.note_byte(b, fin);
      bytes_sent++;
   endtask

   task automatic send_file(logic [7:0] q[$]);
      foreach (q[i]) send_byte(q[i], i == q.size() - 1);
   endtask

   task automatic make_box(ref logic [7:0] q[$], input int lvl, input bit deep);
      logic [7:0]      body[$];
      logic [31:0]     t;
      longint unsigned sz;
      int              sel, mode, n, fixed;
      sel = deep ? 0 : $urandom_range(0, 9);
      if (sel <= 2) begin
         t = CONTAINER_TYPES[$urandom_range(0, NUM_CONTAINERS - 1)];
         if (deep) begin
            if (lvl < 17) make_box(body, lvl + 1, 1'b1);
         end else begin
            n = (lvl < 3) ? $urandom_range(0, 2) : 0;
            repeat (n) make_box(body, lvl + 1, 1'b0);
         end
      end else if (sel <= 4) begin
         case ($urandom_range(0, 3))
            0: begin t = TYPE_DREF; fixed = 8; end
            1: begin t = TYPE_STSD; fixed = 8; end
            2: begin t = TYPE_META; fixed = 4; end
            default: begin t = TYPE_MP4A; fixed = 28; end
         endcase
         n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, fixed - 1) : fixed;
         repeat (n) body.push_back(8'($urandom));
         if (n == fixed && lvl < 3 && $urandom_range(0, 1)) make_box(body, lvl + 1, 1'b0);
      end else if (sel == 5) begin
         t = TYPE_UUID;
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 16 + $urandom_range(0, 4);
         repeat (n) body.push_back(8'($urandom));
      end else begin
         t = $urandom;
         repeat ($urandom_range(0, 8)) body.push_back(8'($urandom));
      end
      mode = $urandom_range(0, 9);
      sz = ((mode == 0) ? 16 : 8) + body.size();
      case ($urandom_range(0, 19))
         0: sz = sz + $urandom_range(1, 4);
         1: sz = (sz > 3) ? sz - $urandom_range(1, 3) : 0;
         2: sz = {$urandom, $urandom};
         default: ;
      endcase
      if (mode == 1) repeat (4) q.push_back(8'h00);
      else if (mode == 0) begin
         q.push_back(8'h00); q.push_back(8'h00); q.push_back(8'h00); q.push_back(8'h01);
         for (int i = 7; i >= 0; i--) q.push_back(sz[8*i +: 8]);
      end else for (int i = 3; i >= 0; i--) q.push_back(sz[8*i +: 8]);
      for (int i = 3; i >= 0; i--) q.push_back(t[8*i +: 8]);
      foreach (body[i]) q.push_back(body[i]);
   endtask

   task automatic random_file();
      logic [7:0] q[$];
      int         sel;
      sel = $urandom_range(0, 19);
      if (sel < 2) repeat ($urandom_range(1, 20)) q.push_back(8'($urandom));
      else if (sel == 2) make_box(q, 0, 1'b1);
      else repeat ($urandom_range(1, 3)) make_box(q, 0, 1'b0);
      if (sel >= 3 && $urandom_range(0, 5) == 0)
         q = q[0 : $urandom_range(0, q.size() - 1)];
      else if (sel >= 3 && $urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
      send_file(q);
   endtask

   initial begin
      box_sb = new();
      send_idle = 0;
      recv_idle = 0;
      hold_go = 1'b0;
      hold_left = 0;
      quiet_cycles = 0;
      bytes_sent = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.data_byte = 8'h00;
      req.is_final = 1'b0;
      rsp.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_file('{8'h00, 8'h00, 8'h00, 8'h08, 8'h66, 8'h72, 8'h65, 8'h65});
      send_file('{8'hFF});
      send_file('{8'h00, 8'h00, 8'h00, 8'h01, 8'h6D, 8'h64, 8'h61, 8'h74,
                  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0A});

      for (int phase_no = 0; phase_no < 3; phase_no++) begin
         send_idle = (phase_no == 0) ? 16 : (phase_no == 1) ? 74 : 0;
         recv_idle = (phase_no == 0) ? 74 : (phase_no == 1) ? 16 : 0;
         bytes_sent = 0;
         if (phase_no == 2) hold_go = 1'b1;
         while (bytes_sent < 170) begin
            random_file();
            if (phase_no == 1 && bytes_sent >= 80 && bytes_sent < 120) begin
               req.valid <= 1'b0;
               while (box_sb.due_q.size() != 0) @(posedge clock);
            end
         end
      end
      req.valid <= 1'b0;

      while (box_sb.due_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (box_sb.errors == 0 && box_sb.due_q.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

/* mp4_box_structure_walker_top.f */
hdl/mbsw_pkg.sv
hdl/mbsw_if.sv
hdl/mbsw_result_queue.sv
hdl/mp4_box_structure_walker_top.sv
bench/mp4_box_structure_walker_top_tb.sv
